// ----- hw/rtl/tcw_pkg.sv -----
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int COPY_CELLS = CELLS - COLUMNS;
    localparam int BOTTOM_POS = (ROWS - 1) * COLUMNS;

    // Field widths fixed by the interface.
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    // Store addressing and sweep counter widths.
    localparam int CELL_AW = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    // Command queue depth.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Mode codes and the newline character.
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [CELL_AW-1:0] addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [CELL_W-1:0]  cell_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       char_code;
        logic [7:0]       color;
        logic [IDX_W-1:0] cell_index;
    } in_item_t;

    typedef struct packed {
        row_t       cursor_row;
        col_t       cursor_col;
        logic [7:0] read_char;
        logic [7:0] read_color;
        logic       scrolled;
    } out_item_t;

    // Classified command handed from the front end to the back end.
    typedef enum logic [2:0] {
        CMD_CHAR,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } cmd_e;

    typedef struct packed {
        cmd_e       op;
        logic [7:0] char_code;
        logic [7:0] color;
        addr_t      addr;
        logic       in_range;
    } cmd_t;

    // Back end status seen by the front end.
    typedef struct packed {
        logic init_busy;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR
    } back_state_e;

endpackage

// ----- hw/rtl/text_console_writer_core.sv -----
// Text console writer: an 80x25 store of character/color cells plus a cursor.
// Input channel item_valid/item_stall/item carries one command per transfer:
// write a character (newline code moves to the start of the next row), clear
// the screen, or read one cell. Output channel result_valid/result_stall/result
// returns exactly one result per command, in order, with the cursor after it.
// With the back end idle, a character, newline or unused mode gets its result
// registered when the back end takes it from the queue; a read also waits on the
// registered read port, a clear on the zeroing sweep and a scroll on the copy.
// A scroll copies the store one cell per cycle through its single read and
// single write port, and a clear zeroes it one cell per cycle; that port pair
// sets the rate. Plain characters sustain one per cycle while the result is not
// stalled, but a scroll holds off further characters until its copy is done.
// A two-entry command queue keeps accepting input while the back end works or
// a result waits. When the receiver stalls, the result is held unchanged and
// the back end stops taking commands once the queue fills, item_stall rises.
// After reset the whole store is zeroed with item_stall held high; the cursor
// starts at row 0, column 0.
module text_console_writer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  tcw_pkg::in_item_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output tcw_pkg::out_item_t  result
);

    tcw_pkg::back_status_t status;
    tcw_pkg::cmd_t         push_cmd;
    tcw_pkg::cmd_t         head_cmd;
    logic                  push;
    logic                  queue_full;
    logic                  head_valid;
    logic                  pop;

    // Front end: accept and classify items.
    tcw_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .status     (status),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue between front and back.
    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: cursor, screen store, scroll and clear sweeps.
    tcw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (pop),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- hw/rtl/tcw_queue.sv -----
module tcw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcw_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output tcw_pkg::cmd_t head_cmd
);

    tcw_pkg::cmd_t                  slot_reg [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [tcw_pkg::QCNT_W-1:0]     count_reg;
    logic [tcw_pkg::QCNT_W-1:0]     count_next;

    assign full       = (count_reg == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/tcw_front.sv -----
module tcw_front (
    input  logic                  item_valid,
    output logic                  item_stall,
    input  tcw_pkg::in_item_t     item,
    input  tcw_pkg::back_status_t status,
    input  logic                  queue_full,
    output logic                  push,
    output tcw_pkg::cmd_t         push_cmd
);

    // Hold off input while the queue is full or the store is still being cleared.
    assign item_stall = queue_full || status.init_busy;
    assign push       = item_valid && !item_stall;

    // Classify the item into a back end command.
    always_comb
    begin
        push_cmd.char_code = item.char_code;
        push_cmd.color     = item.color;
        push_cmd.addr      = tcw_pkg::addr_t'(item.cell_index);
        push_cmd.in_range  = (32'(item.cell_index) < tcw_pkg::CELLS);
        case (item.mode)
            tcw_pkg::MODE_WRITE:
            begin
                push_cmd.op = (item.char_code == tcw_pkg::NEWLINE_CODE) ?
                              tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_CHAR;
            end
            tcw_pkg::MODE_CLEAR: push_cmd.op = tcw_pkg::CMD_CLEAR;
            tcw_pkg::MODE_READ:  push_cmd.op = tcw_pkg::CMD_READ;
            default:             push_cmd.op = tcw_pkg::CMD_NOP;
        endcase
    end

endmodule

// ----- hw/rtl/tcw_back.sv -----
module tcw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  tcw_pkg::cmd_t         cmd,
    output logic                  cmd_pop,
    output tcw_pkg::back_status_t status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output tcw_pkg::out_item_t    result
);

    tcw_pkg::back_state_e state_reg;
    tcw_pkg::back_state_e state_next;
    tcw_pkg::cnt_t        cnt_reg;
    tcw_pkg::cnt_t        cnt_next;
    tcw_pkg::row_t        row_reg;
    tcw_pkg::row_t        row_next;
    tcw_pkg::col_t        col_reg;
    tcw_pkg::col_t        col_next;
    tcw_pkg::addr_t       pos_reg;
    tcw_pkg::addr_t       pos_next;
    logic                 rd_ok_reg;
    logic                 rd_ok_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tcw_pkg::out_item_t   out_reg;
    tcw_pkg::out_item_t   out_next;

    tcw_pkg::cell_t       mem [tcw_pkg::CELLS];
    tcw_pkg::cell_t       rd_data_reg;
    logic                 mem_we;
    tcw_pkg::addr_t       mem_wa;
    tcw_pkg::cell_t       mem_wd;
    tcw_pkg::addr_t       mem_ra;

    logic                 take;
    logic                 at_last_col;
    logic                 at_last_row;
    logic                 emit;
    logic [7:0]           emit_char;
    logic [7:0]           emit_color;
    logic                 emit_scrolled;

    // A command is taken only when the result register is free by the next edge.
    assign take        = (state_reg == tcw_pkg::ST_IDLE) && cmd_valid &&
                         (!out_valid_reg || !result_stall);
    assign cmd_pop     = take;
    assign at_last_col = (col_reg == tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1));
    assign at_last_row = (row_reg == tcw_pkg::row_t'(tcw_pkg::ROWS - 1));

    assign status.init_busy = (state_reg == tcw_pkg::ST_INIT);
    assign result_valid     = out_valid_reg;
    assign result           = out_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR:
            begin
                if (cnt_reg == tcw_pkg::cnt_t'(tcw_pkg::CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    case (cmd.op)
                        tcw_pkg::CMD_CLEAR: state_next = tcw_pkg::ST_CLEAR;
                        tcw_pkg::CMD_READ:  state_next = tcw_pkg::ST_READ;
                        tcw_pkg::CMD_CHAR:
                        begin
                            if (at_last_col && at_last_row)
                            begin
                                state_next = tcw_pkg::ST_SCROLL;
                            end
                        end
                        tcw_pkg::CMD_NEWLINE:
                        begin
                            if (at_last_row)
                            begin
                                state_next = tcw_pkg::ST_SCROLL;
                            end
                        end
                        default: state_next = tcw_pkg::ST_IDLE;
                    endcase
                end
            end
            tcw_pkg::ST_READ: state_next = tcw_pkg::ST_IDLE;
            tcw_pkg::ST_SCROLL:
            begin
                if (cnt_reg == tcw_pkg::cnt_t'(tcw_pkg::CELLS))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default: state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    // Datapath, store access and result formation.
    always_comb
    begin
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        pos_next      = pos_reg;
        rd_ok_next    = rd_ok_reg;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = '0;
        mem_ra        = '0;
        emit          = 1'b0;
        emit_char     = '0;
        emit_color    = '0;
        emit_scrolled = 1'b0;
        case (state_reg)
            tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR:
            begin
                // Zero one cell per cycle.
                mem_we = 1'b1;
                mem_wa = tcw_pkg::addr_t'(cnt_reg);
                if (cnt_reg == tcw_pkg::cnt_t'(tcw_pkg::CELLS - 1))
                begin
                    cnt_next = '0;
                    emit     = (state_reg == tcw_pkg::ST_CLEAR);
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (take)
                begin
                    case (cmd.op)
                        tcw_pkg::CMD_CHAR:
                        begin
                            mem_we = 1'b1;
                            mem_wa = pos_reg;
                            mem_wd = {cmd.color, cmd.char_code};
                            if (!at_last_col)
                            begin
                                col_next = col_reg + 1'b1;
                                pos_next = pos_reg + 1'b1;
                                emit     = 1'b1;
                            end
                            else if (!at_last_row)
                            begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                                pos_next = pos_reg + 1'b1;
                                emit     = 1'b1;
                            end
                            else
                            begin
                                col_next = '0;
                                pos_next = tcw_pkg::addr_t'(tcw_pkg::BOTTOM_POS);
                            end
                        end
                        tcw_pkg::CMD_NEWLINE:
                        begin
                            col_next = '0;
                            if (!at_last_row)
                            begin
                                row_next = row_reg + 1'b1;
                                pos_next = pos_reg - tcw_pkg::addr_t'(col_reg) +
                                           tcw_pkg::addr_t'(tcw_pkg::COLUMNS);
                                emit     = 1'b1;
                            end
                            else
                            begin
                                pos_next = tcw_pkg::addr_t'(tcw_pkg::BOTTOM_POS);
                            end
                        end
                        tcw_pkg::CMD_CLEAR:
                        begin
                            row_next = '0;
                            col_next = '0;
                            pos_next = '0;
                        end
                        tcw_pkg::CMD_READ:
                        begin
                            mem_ra     = cmd.in_range ? cmd.addr : '0;
                            rd_ok_next = cmd.in_range;
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            tcw_pkg::ST_READ:
            begin
                emit       = 1'b1;
                emit_char  = rd_ok_reg ? rd_data_reg[7:0] : '0;
                emit_color = rd_ok_reg ? rd_data_reg[15:8] : '0;
            end
            tcw_pkg::ST_SCROLL:
            begin
                // Read one row ahead, write the cell fetched on the previous cycle;
                // past the copied region the bottom row is filled with zeros.
                if (32'(cnt_reg) < tcw_pkg::COPY_CELLS)
                begin
                    mem_ra = tcw_pkg::addr_t'(cnt_reg + tcw_pkg::cnt_t'(tcw_pkg::COLUMNS));
                end
                if (cnt_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = tcw_pkg::addr_t'(cnt_reg - 1'b1);
                    mem_wd = (32'(cnt_reg) <= tcw_pkg::COPY_CELLS) ? rd_data_reg : '0;
                end
                if (cnt_reg == tcw_pkg::cnt_t'(tcw_pkg::CELLS))
                begin
                    cnt_next      = '0;
                    emit          = 1'b1;
                    emit_scrolled = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: cnt_next = '0;
        endcase

        // Result register: hold while stalled, load on completion.
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next      = 1'b1;
            out_next.cursor_row = row_next;
            out_next.cursor_col = col_next;
            out_next.read_char  = emit_char;
            out_next.read_color = emit_color;
            out_next.scrolled   = emit_scrolled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            pos_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            pos_reg       <= pos_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Screen store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

endmodule

// ----- hw/rtl/tcw_checker.sv -----
module tcw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_stall,
    input tcw_pkg::out_item_t  result
);

    // A stalled result stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // The reported cursor is always on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(result.cursor_row) < tcw_pkg::ROWS) &&
                         (32'(result.cursor_col) < tcw_pkg::COLUMNS))
        else $error("cursor outside the screen");

    // A scroll leaves the cursor at the start of the bottom row.
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.scrolled |->
            (32'(result.cursor_row) == tcw_pkg::ROWS - 1) && (result.cursor_col == '0))
        else $error("scroll with cursor off the bottom row start");

    // A scrolling write never carries read data.
    a_scroll_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.scrolled |->
            (result.read_char == '0) && (result.read_color == '0))
        else $error("scroll result carries read data");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
